### src/sq_pkg.sv
// shared types and constants for the silhouette score engine
`timescale 1ns / 1ps
package sq_pkg;

  // input item function codes
  localparam logic [1:0] FUNC_DIST  = 2'd0;
  localparam logic [1:0] FUNC_LABEL = 2'd1;
  localparam logic [1:0] FUNC_SCORE = 2'd2;

  localparam int unsigned FRAC_BITS  = 14;
  localparam int unsigned SCORE_W    = 16;
  localparam int unsigned LABEL_W    = 5;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned DIN_W      = 16;
  localparam int unsigned NP_W       = 7;
  localparam logic [LABEL_W-1:0] LBL_UNASSIGNED = 5'd16;
  localparam logic signed [SCORE_W-1:0] ONE_Q = 16'sd16384;

  // controller states, one-hot
  typedef enum logic [14:0] {
    ST_IDLE   = 15'h0001,
    ST_SZ_RD  = 15'h0002,
    ST_SZ_UPD = 15'h0004,
    ST_PT_RD  = 15'h0008,
    ST_PT_CHK = 15'h0010,
    ST_Q_RD   = 15'h0020,
    ST_Q_ADD  = 15'h0040,
    ST_B_INIT = 15'h0080,
    ST_B_SRCH = 15'h0100,
    ST_PROD   = 15'h0200,
    ST_DSET   = 15'h0400,
    ST_DIV    = 15'h0800,
    ST_ACC    = 15'h1000,
    ST_FDIV   = 15'h2000,
    ST_FIN    = 15'h4000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic ld_dist;
    logic ld_lbl;
    logic start;
    logic lbl_use_q;
    logic sz_upd;
    logic p_step;
    logic pt_latch;
    logic add_one;
    logic q_clr;
    logic q_add;
    logic b_init;
    logic b_step;
    logic prod;
    logic dset;
    logic div_cap;
    logic acc;
    logic fdiv_start;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic p_last;
    logic q_last;
    logic m_last;
    logic assigned;
    logic single;
    logic zero_case;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

### src/sq_if.sv
// valid/ready channel interfaces for load/compute items and score results
`timescale 1ns / 1ps
interface sq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [5:0]  row;
  logic [5:0]  col;
  logic [15:0] distance;
  logic [4:0]  label;

  modport source (output valid, func, row, col, distance, label, input ready);
  modport sink (input valid, func, row, col, distance, label, output ready);
endinterface

interface sq_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] score;
  logic               single_cluster;

  modport source (output valid, score, single_cluster, input ready);
  modport sink (input valid, score, single_cluster, output ready);
endinterface

### src/sq_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module sq_div #(
  parameter int unsigned NW = 43,
  parameter int unsigned DW = 29
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);
  localparam int unsigned CNTW = $clog2(NW + 1);

  logic [NW-1:0]   num_q, num_d;
  logic [DW-1:0]   rem_q, rem_d, den_q;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DW:0]     sh, diff;
  logic            take;

  // one trial subtraction step
  always_comb begin
    sh   = {rem_q, num_q[NW-1]};
    diff = sh - {1'b0, den_q};
    take = ~diff[DW];
    rem_d  = rem_q;
    num_d  = num_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      num_d  = num_i;
      cnt_d  = CNTW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = take ? diff[DW-1:0] : sh[DW-1:0];
      num_d = {num_q[NW-2:0], take};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operands
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;
endmodule

### src/sq_datapath.sv
// storage, accumulators and arithmetic of the silhouette score engine
`timescale 1ns / 1ps
module sq_datapath #(
  parameter int unsigned MAX_POINTS   = 64,
  parameter int unsigned MAX_CLUSTERS = 16,
  parameter int unsigned DIST_BITS    = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sq_pkg::NP_W-1:0]         cfg_data_i,
  input  logic [sq_pkg::IDX_W-1:0]        row_i,
  input  logic [sq_pkg::IDX_W-1:0]        col_i,
  input  logic [sq_pkg::DIN_W-1:0]        distance_i,
  input  logic [sq_pkg::LABEL_W-1:0]      label_i,
  input  sq_pkg::cmd_t                    cmd_i,
  output sq_pkg::status_t                 status_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [sq_pkg::SCORE_W-1:0] out_score_o,
  output logic                            out_single_o
);
  localparam int unsigned PW   = $clog2(MAX_POINTS);
  localparam int unsigned NEW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned CIW  = $clog2(MAX_CLUSTERS);
  localparam int unsigned AW   = $clog2(MAX_POINTS * MAX_POINTS);
  localparam int unsigned SZW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned SMW  = DIST_BITS + $clog2(MAX_POINTS);
  localparam int unsigned PRW  = SMW + SZW;
  localparam int unsigned NW   = PRW + sq_pkg::FRAC_BITS;
  localparam int unsigned TW   = $clog2(MAX_POINTS) + 16;
  localparam int unsigned NCW  = $clog2(MAX_CLUSTERS + 1);

  // stores
  logic [DIST_BITS-1:0]       dmem [MAX_POINTS*MAX_POINTS];
  logic [sq_pkg::LABEL_W-1:0] lmem [MAX_POINTS];
  logic [MAX_POINTS-1:0]      lvld_q;
  logic [SMW-1:0]             sums_q [MAX_CLUSTERS];
  logic [SZW-1:0]             sizes_q [MAX_CLUSTERS];

  logic [DIST_BITS-1:0]       dist_rd_q;
  logic [sq_pkg::LABEL_W-1:0] lbl_rd_q;
  logic                       lbl_rd_vld_q;
  logic [sq_pkg::LABEL_W-1:0] lbl_eff;
  logic                       lbl_assigned;
  logic [CIW-1:0]             lbl_idx;

  logic [sq_pkg::NP_W-1:0]    np_q;
  logic [NEW-1:0]             n_eff;
  logic [PW-1:0]              p_q, q_q, lbl_addr;
  logic [CIW-1:0]             m_q, c_q;
  logic                       p_last, q_last;

  logic [SMW-1:0]             sa_q, sb_q;
  logic [SZW-1:0]             na_q, nb_q;
  logic                       found_q;
  logic [PRW-1:0]             nbv_q, nav_q;
  logic                       ge;
  logic signed [TW-1:0]       total_q;
  logic signed [TW-1:0]       tot_fin;
  logic signed [sq_pkg::SCORE_W-1:0] s_q;
  logic                       neg_q;
  logic                       single_q;

  logic [AW-1:0]              wr_addr, rd_addr;
  logic                       wr_ok;
  logic [CIW-1:0]             sel_idx;
  logic [SMW-1:0]             sum_sel;
  logic [SZW-1:0]             size_sel;
  logic [PRW-1:0]             lhs, rhs;
  logic                       b_take;
  logic [NCW-1:0]             nonempty;

  logic                       div_start, div_done;
  logic [NW-1:0]              div_num, div_quo;
  logic [PRW-1:0]             div_den;
  logic [TW-1:0]              tot_abs;
  logic signed [sq_pkg::SCORE_W-1:0] quo_s;

  logic                       out_vld_q;
  logic signed [sq_pkg::SCORE_W-1:0] score_q;
  logic                       out_single_q;

  // effective point count
  always_comb begin
    if (np_q == '0) begin
      n_eff = NEW'(1);
    end else if (32'(np_q) > MAX_POINTS) begin
      n_eff = NEW'(MAX_POINTS);
    end else begin
      n_eff = NEW'(np_q);
    end
  end

  assign p_last = (32'(p_q) == 32'(n_eff) - 1);
  assign q_last = (32'(q_q) == 32'(n_eff) - 1);

  // label read data with unwritten entries reading as unassigned
  assign lbl_eff      = lbl_rd_vld_q ? lbl_rd_q : sq_pkg::LBL_UNASSIGNED;
  assign lbl_assigned = (32'(lbl_eff) < MAX_CLUSTERS);
  assign lbl_idx      = CIW'(lbl_eff);

  // addresses
  assign wr_ok    = (32'(row_i) < MAX_POINTS) && (32'(col_i) < MAX_POINTS);
  assign wr_addr  = AW'(row_i) * AW'(MAX_POINTS) + AW'(col_i);
  assign rd_addr  = AW'(p_q) * AW'(MAX_POINTS) + AW'(q_q);
  assign lbl_addr = cmd_i.lbl_use_q ? q_q : p_q;

  // distance memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_dist && wr_ok) begin
      dmem[wr_addr] <= DIST_BITS'(distance_i);
    end
    dist_rd_q <= dmem[rd_addr];
  end

  // label memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_lbl && (32'(row_i) < MAX_POINTS)) begin
      lmem[PW'(row_i)] <= label_i;
    end
    lbl_rd_q <= lmem[lbl_addr];
  end

  // label valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvld_q       <= '0;
      lbl_rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.ld_lbl && (32'(row_i) < MAX_POINTS)) begin
        lvld_q[PW'(row_i)] <= 1'b1;
      end
      lbl_rd_vld_q <= lvld_q[lbl_addr];
    end
  end

  // cluster table read port
  always_comb begin
    if (cmd_i.sz_upd || cmd_i.q_add) begin
      sel_idx = lbl_idx;
    end else if (cmd_i.b_init) begin
      sel_idx = c_q;
    end else begin
      sel_idx = m_q;
    end
    sum_sel  = sums_q[sel_idx];
    size_sel = sizes_q[sel_idx];
  end

  // nearest other cluster compare
  assign lhs    = PRW'(sum_sel) * PRW'(nb_q);
  assign rhs    = PRW'(sb_q) * PRW'(size_sel);
  assign b_take = (m_q != c_q) && (size_sel != '0) && (!found_q || (lhs < rhs));

  // non-empty cluster count
  always_comb begin
    nonempty = '0;
    for (int i = 0; i < MAX_CLUSTERS; i++) begin
      nonempty = nonempty + NCW'(sizes_q[i] != '0);
    end
  end

  // cluster sums and sizes
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        sizes_q[i] <= '0;
      end
    end else if (cmd_i.sz_upd && lbl_assigned) begin
      sizes_q[sel_idx] <= size_sel + 1'b1;
    end
    if (cmd_i.q_clr) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        sums_q[i] <= '0;
      end
    end else if (cmd_i.q_add && lbl_assigned && (q_q != p_q)) begin
      sums_q[sel_idx] <= sum_sel + SMW'(dist_rd_q);
    end
  end

  // counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_q     <= sq_pkg::NP_W'(64);
      p_q      <= '0;
      q_q      <= '0;
      m_q      <= '0;
      found_q  <= 1'b0;
      single_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        np_q <= cfg_data_i;
      end
      single_q <= (nonempty < NCW'(2));
      if (cmd_i.start) begin
        p_q <= '0;
      end else if (cmd_i.p_step) begin
        p_q <= p_last ? '0 : p_q + 1'b1;
      end
      if (cmd_i.q_clr) begin
        q_q <= '0;
      end else if (cmd_i.q_add) begin
        q_q <= q_last ? '0 : q_q + 1'b1;
      end
      if (cmd_i.b_init) begin
        m_q     <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.b_step) begin
        m_q <= m_q + 1'b1;
        if (b_take) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // divider operands and signed quotient
  assign ge        = (nbv_q >= nav_q);
  // running total including the last point's score, used for the final division
  assign tot_fin   = total_q + TW'(s_q);
  assign tot_abs   = tot_fin[TW-1] ? TW'(-tot_fin) : TW'(tot_fin);
  assign div_start = (cmd_i.dset && !(ge && nbv_q == '0)) || cmd_i.fdiv_start;
  assign div_num   = cmd_i.fdiv_start ? NW'(tot_abs)
                   : {(ge ? nbv_q - nav_q : nav_q - nbv_q), {sq_pkg::FRAC_BITS{1'b0}}};
  assign div_den   = cmd_i.fdiv_start ? PRW'(n_eff) : (ge ? nbv_q : nav_q);
  assign quo_s     = neg_q ? -$signed(div_quo[sq_pkg::SCORE_W-1:0])
                           : $signed(div_quo[sq_pkg::SCORE_W-1:0]);

  sq_div #(
    .NW(NW),
    .DW(PRW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // per point working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.pt_latch) begin
      c_q <= lbl_idx;
    end
    if (cmd_i.b_init) begin
      if (size_sel == SZW'(1)) begin
        sa_q <= '0;
        na_q <= SZW'(1);
      end else begin
        sa_q <= sum_sel;
        na_q <= size_sel - 1'b1;
      end
    end
    if (cmd_i.b_step && b_take) begin
      sb_q <= sum_sel;
      nb_q <= size_sel;
    end
    if (cmd_i.prod) begin
      nbv_q <= PRW'(sb_q) * PRW'(na_q);
      nav_q <= PRW'(sa_q) * PRW'(nb_q);
    end
    // point score starts at zero for skipped and single cluster points
    if (cmd_i.pt_latch) begin
      s_q <= '0;
    end else if (cmd_i.dset) begin
      neg_q <= !ge;
      s_q   <= '0;
    end else if (cmd_i.fdiv_start) begin
      neg_q <= tot_fin[TW-1];
    end else if (cmd_i.div_cap && div_done) begin
      s_q <= quo_s;
    end
    if (cmd_i.start) begin
      total_q <= '0;
    end else if (cmd_i.add_one) begin
      total_q <= total_q + TW'(sq_pkg::ONE_Q);
    end else if (cmd_i.acc) begin
      total_q <= total_q + TW'(s_q);
    end
    if (cmd_i.out_load) begin
      score_q      <= s_q;
      out_single_q <= single_q;
    end
  end

  // status
  assign status_o.p_last    = p_last;
  assign status_o.q_last    = q_last;
  assign status_o.m_last    = (32'(m_q) == MAX_CLUSTERS - 1);
  assign status_o.assigned  = lbl_assigned;
  assign status_o.single    = single_q;
  assign status_o.zero_case = ge && (nbv_q == '0);
  assign status_o.div_done  = div_done;
  assign status_o.out_busy  = out_vld_q && !out_ready_i;

  assign out_valid_o  = out_vld_q;
  assign out_score_o  = score_q;
  assign out_single_o = out_single_q;
endmodule

### src/sq_ctrl.sv
// sequencer for loads and the compute pass
`timescale 1ns / 1ps
module sq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      in_func_i,
  output logic            in_ready_o,
  input  sq_pkg::status_t status_i,
  output sq_pkg::cmd_t    cmd_o
);
  sq_pkg::state_e state_q, state_d;
  logic           xfer;

  assign in_ready_o = (state_q == sq_pkg::ST_IDLE);
  assign xfer       = in_valid_i && in_ready_o;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      sq_pkg::ST_IDLE: begin
        if (xfer) begin
          if (in_func_i == sq_pkg::FUNC_DIST) begin
            cmd_o.ld_dist = 1'b1;
          end else if (in_func_i == sq_pkg::FUNC_LABEL) begin
            cmd_o.ld_lbl = 1'b1;
          end else if (in_func_i == sq_pkg::FUNC_SCORE) begin
            cmd_o.start = 1'b1;
            state_d     = sq_pkg::ST_SZ_RD;
          end
        end
      end
      sq_pkg::ST_SZ_RD: state_d = sq_pkg::ST_SZ_UPD;
      sq_pkg::ST_SZ_UPD: begin
        cmd_o.sz_upd = 1'b1;
        cmd_o.p_step = 1'b1;
        state_d = status_i.p_last ? sq_pkg::ST_PT_RD : sq_pkg::ST_SZ_RD;
      end
      sq_pkg::ST_PT_RD: state_d = sq_pkg::ST_PT_CHK;
      sq_pkg::ST_PT_CHK: begin
        cmd_o.pt_latch = 1'b1;
        if (!status_i.assigned) begin
          state_d = sq_pkg::ST_ACC;
        end else if (status_i.single) begin
          cmd_o.add_one = 1'b1;
          state_d = sq_pkg::ST_ACC;
        end else begin
          cmd_o.q_clr = 1'b1;
          state_d = sq_pkg::ST_Q_RD;
        end
      end
      sq_pkg::ST_Q_RD: begin
        cmd_o.lbl_use_q = 1'b1;
        state_d = sq_pkg::ST_Q_ADD;
      end
      sq_pkg::ST_Q_ADD: begin
        cmd_o.q_add = 1'b1;
        state_d = status_i.q_last ? sq_pkg::ST_B_INIT : sq_pkg::ST_Q_RD;
      end
      sq_pkg::ST_B_INIT: begin
        cmd_o.b_init = 1'b1;
        state_d = sq_pkg::ST_B_SRCH;
      end
      sq_pkg::ST_B_SRCH: begin
        cmd_o.b_step = 1'b1;
        if (status_i.m_last) begin
          state_d = sq_pkg::ST_PROD;
        end
      end
      sq_pkg::ST_PROD: begin
        cmd_o.prod = 1'b1;
        state_d = sq_pkg::ST_DSET;
      end
      sq_pkg::ST_DSET: begin
        cmd_o.dset = 1'b1;
        state_d = status_i.zero_case ? sq_pkg::ST_ACC : sq_pkg::ST_DIV;
      end
      sq_pkg::ST_DIV: begin
        cmd_o.div_cap = 1'b1;
        if (status_i.div_done) begin
          state_d = sq_pkg::ST_ACC;
        end
      end
      // add the point's score (zero when skipped) and advance
      sq_pkg::ST_ACC: begin
        cmd_o.acc    = 1'b1;
        cmd_o.p_step = 1'b1;
        if (status_i.p_last) begin
          cmd_o.fdiv_start = 1'b1;
          state_d = sq_pkg::ST_FDIV;
        end else begin
          state_d = sq_pkg::ST_PT_RD;
        end
      end
      sq_pkg::ST_FDIV: begin
        cmd_o.div_cap = 1'b1;
        if (status_i.div_done) begin
          state_d = sq_pkg::ST_FIN;
        end
      end
      sq_pkg::ST_FIN: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = sq_pkg::ST_IDLE;
        end
      end
      default: state_d = sq_pkg::ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

### src/silhouette_score.sv
// silhouette score engine top level: distance/label loads and the mean silhouette
// loads can follow back to back; a compute closes the input until its result is
// loaded into the output register, which waits while an earlier result stalls; the
// compute time is set by the single label/distance read port and the shared
// bit-serial divider
// reset (asynchronous, active low): labels unassigned, num_points 64, distances undefined
`timescale 1ns / 1ps
module silhouette_score #(
  parameter int unsigned MAX_POINTS   = 64,
  parameter int unsigned MAX_CLUSTERS = 16,
  parameter int unsigned DIST_BITS    = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [sq_pkg::NP_W-1:0] cfg_data_i,
  sq_in_if.sink                   in_i,
  sq_out_if.source                out_o
);
  sq_pkg::cmd_t    cmd;
  sq_pkg::status_t status;

  // sequencer
  sq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_func_i (in_i.func),
    .in_ready_o(in_i.ready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // storage and arithmetic
  sq_datapath #(
    .MAX_POINTS  (MAX_POINTS),
    .MAX_CLUSTERS(MAX_CLUSTERS),
    .DIST_BITS   (DIST_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .row_i       (in_i.row),
    .col_i       (in_i.col),
    .distance_i  (in_i.distance),
    .label_i     (in_i.label),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_score_o (out_o.score),
    .out_single_o(out_o.single_cluster)
  );
endmodule

### src/sq_checker.sv
// port level checks for the silhouette score engine
`timescale 1ns / 1ps
module sq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_func,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_score,
  input logic        out_single
);
  // result holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_score))
    else $error("result dropped before transfer");

  // score stays within plus or minus one in Q2.14
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> ($signed(out_score) >= -16384) && ($signed(out_score) <= 16384))
    else $error("score out of range");

  // a single cluster gives a non-negative score
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_single |-> !out_score[15])
    else $error("negative score with single cluster");

  // a compute transfer closes the input side
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_func == sq_pkg::FUNC_SCORE) |=> !in_ready)
    else $error("input open during compute");
endmodule

bind silhouette_score sq_checker u_sq_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_func   (in_i.func),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_score (out_o.score),
  .out_single(out_o.single_cluster)
);
